[hw/rtl/spf_pkg.sv]
// Package: shared widths, walk state type and the modulo-reduce helper.
package spf_pkg;

    localparam int POS_W    = 6;   // width of a canonical position / native vertex
    localparam int IDX_W    = 5;   // width of compact index and reduced entry
    localparam int MARK_DEPTH = 64;
    localparam int MARK_AW  = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_NATIVE,
        ST_CANON0,
        ST_CANON1,
        ST_FLUSH
    } state_t;

    // Reduce v modulo n (n nonzero) by six restoring compare-and-subtract steps.
    function automatic logic [POS_W-1:0] mod_reduce(
        input logic [POS_W-1:0] v,
        input logic [POS_W-1:0] n
    );
        logic [2*POS_W-1:0] r;
        logic [2*POS_W-1:0] d;
        r = {{POS_W{1'b0}}, v};
        for (int k = POS_W - 1; k >= 0; k--)
        begin
            d = {{POS_W{1'b0}}, n} << k;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[POS_W-1:0];
    endfunction

endpackage

[hw/rtl/spf_ram.sv]
// Generic single-port RAM with registered read data.
module spf_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/symmetrized_permutation_fold.sv]
// Top level: loads a doubled canonical labelling and folds it onto the base vertices.
//
// Input channel (in_valid / in_stall): one transaction per labelling element,
// carrying canon_pos_of_native and native_at_canon_pos for index i; final_item
// closes the run. Elements load one per cycle into two RAMs; past 2*MAX_ENTRIES
// they are dropped, but a final one still starts the walk. n is half the count,
// rounded down.
// After the final transaction in_stall stays high while the walk runs over
// canonical positions 0 .. 2n-1, stopping early once n mappings are emitted. A
// position whose mark is already cleared is skipped; each emitted mapping takes
// the steps mark check, native read with modulo reduce, and reads of both
// copies' canonical positions, each read waiting on the registered RAM read
// data. An end check and a flush close the run.
// Output channel (out_valid / out_stall): one transaction per mapping with
// compact_index, native_entry, conflict and end_of_run on the last one. A
// result waits in a holding stage until the next one (or the end of
// the walk) tells whether it is the last; a stalled receiver holds the walk
// once the output register and holding stage are both full. Nothing is lost.
// Reset: empty run, all marks set, no output; the RAMs are not cleared. At the
// end of each run all marks are set again.
module symmetrized_permutation_fold #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [spf_pkg::POS_W-1:0] canon_pos_of_native,
    input  logic [spf_pkg::POS_W-1:0] native_at_canon_pos,
    input  logic                      final_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [spf_pkg::IDX_W-1:0] compact_index,
    output logic [spf_pkg::IDX_W-1:0] native_entry,
    output logic                      conflict,
    output logic                      end_of_run
);

    localparam int DEPTH = 2 * MAX_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);        // load count and walk position
    localparam int NW    = $clog2(MAX_ENTRIES + 1);  // n, compact counter, entry

    // Control state
    spf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   load_cnt_reg, load_cnt_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NW-1:0]   cmp_reg, cmp_next;
    logic [spf_pkg::MARK_DEPTH-1:0] mark_reg, mark_next;
    logic            hold_vld_reg, hold_vld_next;
    logic            out_valid_reg, out_valid_next;

    // Payload
    logic [NW-1:0]   entry_reg, entry_next;
    logic            conf0_reg, conf0_next;
    logic [NW-1:0]   hold_idx_reg, hold_idx_next;
    logic [NW-1:0]   hold_ent_reg, hold_ent_next;
    logic            hold_conf_reg, hold_conf_next;
    logic [NW-1:0]   out_idx_reg, out_idx_next;
    logic [NW-1:0]   out_ent_reg, out_ent_next;
    logic            out_conf_reg, out_conf_next;
    logic            out_end_reg, out_end_next;

    // RAM ports
    logic                      mem_we;
    logic [AW-1:0]             nat_addr;
    logic [AW-1:0]             can_addr;
    logic [spf_pkg::POS_W-1:0] nat_rdata;
    logic [spf_pkg::POS_W-1:0] can_rdata;

    logic                      in_acc;
    logic                      out_free;
    logic [CW-1:0]             lc_after;
    logic [spf_pkg::POS_W-1:0] entry_mod;
    logic [AW-1:0]             twin_addr;

    spf_ram #(
        .WIDTH (spf_pkg::POS_W),
        .DEPTH (DEPTH)
    ) u_canon_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (can_addr),
        .wdata (canon_pos_of_native),
        .rdata (can_rdata)
    );

    spf_ram #(
        .WIDTH (spf_pkg::POS_W),
        .DEPTH (DEPTH)
    ) u_native_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (nat_addr),
        .wdata (native_at_canon_pos),
        .rdata (nat_rdata)
    );

    assign in_stall = (state_reg != spf_pkg::ST_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Canonical position of the second copy lives at entry + n.
    assign twin_addr = AW'(CW'(entry_reg) + CW'(n_reg));
    assign entry_mod = spf_pkg::mod_reduce(nat_rdata, spf_pkg::POS_W'(n_reg));

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        cmp_next       = cmp_reg;
        mark_next      = mark_reg;
        hold_vld_next  = hold_vld_reg;
        out_valid_next = out_valid_reg;
        entry_next     = entry_reg;
        conf0_next     = conf0_reg;
        hold_idx_next  = hold_idx_reg;
        hold_ent_next  = hold_ent_reg;
        hold_conf_next = hold_conf_reg;
        out_idx_next   = out_idx_reg;
        out_ent_next   = out_ent_reg;
        out_conf_next  = out_conf_reg;
        out_end_next   = out_end_reg;
        mem_we         = 1'b0;
        nat_addr       = AW'(pos_reg);
        can_addr       = twin_addr;
        lc_after       = load_cnt_reg;

        // Drop the output transaction once taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            spf_pkg::ST_LOAD:
            begin
                nat_addr = AW'(load_cnt_reg);
                can_addr = AW'(load_cnt_reg);
                if (in_acc)
                begin
                    if (load_cnt_reg < CW'(DEPTH))
                    begin
                        mem_we   = 1'b1;
                        lc_after = load_cnt_reg + CW'(1);
                    end
                    load_cnt_next = lc_after;
                    if (final_item)
                    begin
                        n_next     = NW'(lc_after >> 1);
                        pos_next   = '0;
                        state_next = spf_pkg::ST_CHECK;
                    end
                end
            end

            spf_pkg::ST_CHECK:
            begin
                if ((pos_reg < CW'({n_reg, 1'b0})) && (cmp_reg < n_reg))
                begin
                    if (mark_reg[spf_pkg::MARK_AW'(pos_reg)])
                    begin
                        state_next = spf_pkg::ST_NATIVE;
                    end
                    else
                    begin
                        pos_next = pos_reg + CW'(1);
                    end
                end
                else
                begin
                    state_next = spf_pkg::ST_FLUSH;
                end
            end

            spf_pkg::ST_NATIVE:
            begin
                entry_next = NW'(entry_mod);
                can_addr   = AW'(entry_mod);
                state_next = spf_pkg::ST_CANON0;
            end

            spf_pkg::ST_CANON0:
            begin
                conf0_next           = !mark_reg[can_rdata];
                mark_next[can_rdata] = 1'b0;
                state_next           = spf_pkg::ST_CANON1;
            end

            spf_pkg::ST_CANON1:
            begin
                if (!hold_vld_reg || out_free)
                begin
                    if (hold_vld_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = hold_idx_reg;
                        out_ent_next   = hold_ent_reg;
                        out_conf_next  = hold_conf_reg;
                        out_end_next   = 1'b0;
                    end
                    hold_vld_next        = 1'b1;
                    hold_idx_next        = cmp_reg;
                    hold_ent_next        = entry_reg;
                    hold_conf_next       = conf0_reg || !mark_reg[can_rdata];
                    mark_next[can_rdata] = 1'b0;
                    cmp_next             = cmp_reg + NW'(1);
                    pos_next             = pos_reg + CW'(1);
                    state_next           = spf_pkg::ST_CHECK;
                end
            end

            spf_pkg::ST_FLUSH:
            begin
                if (!hold_vld_reg || out_free)
                begin
                    if (hold_vld_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = hold_idx_reg;
                        out_ent_next   = hold_ent_reg;
                        out_conf_next  = hold_conf_reg;
                        out_end_next   = 1'b1;
                    end
                    hold_vld_next = 1'b0;
                    mark_next     = '1;
                    load_cnt_next = '0;
                    cmp_next      = '0;
                    state_next    = spf_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = spf_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spf_pkg::ST_LOAD;
            load_cnt_reg  <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            cmp_reg       <= '0;
            mark_reg      <= '1;
            hold_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            cmp_reg       <= cmp_next;
            mark_reg      <= mark_next;
            hold_vld_reg  <= hold_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        conf0_reg     <= conf0_next;
        hold_idx_reg  <= hold_idx_next;
        hold_ent_reg  <= hold_ent_next;
        hold_conf_reg <= hold_conf_next;
        out_idx_reg   <= out_idx_next;
        out_ent_reg   <= out_ent_next;
        out_conf_reg  <= out_conf_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid     = out_valid_reg;
    assign compact_index = spf_pkg::IDX_W'(out_idx_reg);
    assign native_entry  = spf_pkg::IDX_W'(out_ent_reg);
    assign conflict      = out_conf_reg;
    assign end_of_run    = out_end_reg;

    // The holding stage is always emptied before loading resumes.
    a_hold_empty_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spf_pkg::ST_LOAD) |-> !hold_vld_reg)
        else $error("holding stage occupied during load");

    // The walk never issues more than n mappings.
    a_compact_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != spf_pkg::ST_LOAD) |-> (cmp_reg <= n_reg))
        else $error("compact counter ran past n");

    // A run always closes with every mark set and an empty count.
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spf_pkg::ST_LOAD) && $past(state_reg == spf_pkg::ST_FLUSH))
        |-> ((&mark_reg) && (load_cnt_reg == '0) && (cmp_reg == '0)))
        else $error("run state not cleared after walk");

    // A mapping issued in the last read step leaves a held result behind.
    a_hold_after_map: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spf_pkg::ST_CANON1) && (!hold_vld_reg || out_free))
        |=> (hold_vld_reg && (state_reg == spf_pkg::ST_CHECK)))
        else $error("mapping lost between read step and holding stage");

endmodule
